FILE: hw/rtl/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, codes and constants for the track chunk parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Event kinds carried in a result record.
  localparam logic [2:0] KIND_OFF   = 3'd0;
  localparam logic [2:0] KIND_ON    = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_PROG  = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [31:0] MTRK_TAG = 32'h4D54_726B;

  // One result record as it travels from the parser to the output queue.
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] track_index;
    logic [27:0] delta_ticks;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_value;
  } record_t;

  localparam int unsigned RecordWidth = $bits(record_t);

endpackage

FILE: hw/rtl/midi_track_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses MTrk chunk bytes into note, program, tempo, end-of-track, other and error records.
// ----------------------------------------------------------------------------
// Input channel: drive data_byte_i and raise push; a transaction completes at
// a clock edge with push high and full low. One byte is taken every cycle while full is low.
// Output channel: while empty is low the oldest record is on the result
// ports; a transaction completes at an edge with pop high and empty low.
// Latency: a record caused by a byte is visible the cycle after that byte's
// transaction. Throughput: one byte per cycle while full is low, set by the
// parser state machine; records wait in a QueueDepth-entry queue.
// When the receiver stalls the queue fills; full rises once fewer free
// entries remain than one, so bytes are held back without loss.
// Reset clears the parser to await a track header, track count zero, and
// empties the queue. An error record halts parsing until the next reset.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind_o,
  output logic [15:0] track_index_o,
  output logic [27:0] delta_ticks_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic [23:0] tempo_value_o
);

  logic              accept;
  logic              rec_valid;
  mtep_pkg::record_t rec, head;
  logic              q_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  mtep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (data_byte_i),
    .rec_valid_o  (rec_valid),
    .rec_o        (rec)
  );

  mtep_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_valid),
    .wdata_i (rec),
    .rd_i    (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (q_full)
  );

  assign event_kind_o  = head.event_kind;
  assign track_index_o = head.track_index;
  assign delta_ticks_o = head.delta_ticks;
  assign channel_o     = head.channel;
  assign first_data_o  = head.first_data;
  assign second_data_o = head.second_data;
  assign tempo_value_o = head.tempo_value;

endmodule

FILE: hw/rtl/mtep_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Classifies each byte of the track stream and emits at most one record.
// ----------------------------------------------------------------------------
module mtep_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output logic                rec_valid_o,
  output mtep_pkg::record_t   rec_o
);

  // Parser phase codes.
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_DELTA  = 4'd1;
  localparam logic [3:0] PH_STATUS = 4'd2;
  localparam logic [3:0] PH_DATA1  = 4'd3;
  localparam logic [3:0] PH_DATA2  = 4'd4;
  localparam logic [3:0] PH_SYSEX  = 4'd6;
  localparam logic [3:0] PH_MTYPE  = 4'd7;
  localparam logic [3:0] PH_MLEN   = 4'd8;
  localparam logic [3:0] PH_MSKIP  = 4'd9;
  localparam logic [3:0] PH_HALT   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] hdr_q, hdr_d;
  logic [31:0] remain_q, remain_d;
  logic [27:0] delta_q, delta_d;
  logic [7:0]  rstat_q, rstat_d;
  logic [7:0]  skip_q, skip_d;
  logic [7:0]  held_q, held_d;
  logic [23:0] tempo_q, tempo_d;
  logic [15:0] track_q, track_d;

  logic              emit;
  logic [2:0]        kind;
  logic [3:0]        ch;
  logic [6:0]        d1, d2;
  logic [23:0]       tv;
  logic [7:0]        b;
  logic [7:0]        skip_inc, skip_dec;
  logic [23:0]       tempo_nx;
  logic              meta_done;
  logic [7:0]        meta_type;

  assign b = byte_i;
  assign skip_inc = skip_q + 8'd1;
  assign skip_dec = skip_q - 8'd1;

  // Next-state and record decode for one byte.
  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    remain_d = remain_q;
    delta_d  = delta_q;
    rstat_d  = rstat_q;
    skip_d   = skip_q;
    held_d   = held_q;
    tempo_d  = tempo_q;
    track_d  = track_q;
    emit     = 1'b0;
    kind     = mtep_pkg::KIND_OTHER;
    ch       = 4'd0;
    d1       = 7'd0;
    d2       = 7'd0;
    tv       = 24'd0;
    meta_done = 1'b0;
    meta_type = held_q;
    tempo_nx  = tempo_q;
    if (byte_valid_i && phase_q != PH_HALT) begin
      if (phase_q == PH_HEADER) begin
        hdr_d  = {hdr_q[23:0], b};
        skip_d = skip_inc;
        if (skip_inc == 8'd4 && hdr_d != mtep_pkg::MTRK_TAG) begin
          emit = 1'b1;
          kind = mtep_pkg::KIND_ERROR;
          phase_d = PH_HALT;
        end else if (skip_inc >= 8'd8) begin
          remain_d = hdr_d;
          skip_d   = 8'd0;
          hdr_d    = 32'd0;
          rstat_d  = 8'd0;
          phase_d  = PH_DELTA;
          delta_d  = 28'd0;
        end
      end else if (remain_q == 32'd0) begin
        emit = 1'b1;
        kind = mtep_pkg::KIND_ERROR;
        phase_d = PH_HALT;
      end else begin
        remain_d = remain_q - 32'd1;
        unique case (phase_q)
          PH_DELTA: begin
            delta_d = {delta_q[20:0], b[6:0]};
            if (!b[7]) phase_d = PH_STATUS;
          end
          PH_STATUS, PH_DATA1: begin
            if (phase_q == PH_STATUS && b[7]) begin
              if (b < 8'hF0) begin
                rstat_d = b;
                phase_d = PH_DATA1;
              end else begin
                rstat_d = 8'd0;
                if (b == 8'hF0) phase_d = PH_SYSEX;
                else if (b == 8'hFF) phase_d = PH_MTYPE;
                else begin
                  emit = 1'b1;
                  kind = mtep_pkg::KIND_ERROR;
                  phase_d = PH_HALT;
                end
              end
            end else if (phase_q == PH_STATUS && !rstat_q[7]) begin
              emit = 1'b1;
              kind = mtep_pkg::KIND_ERROR;
              phase_d = PH_HALT;
            end else if (rstat_q[7:4] == 4'hC || rstat_q[7:4] == 4'hD) begin
              // Single data byte events complete here.
              emit = 1'b1;
              ch   = rstat_q[3:0];
              if (rstat_q[7:4] == 4'hC) begin
                kind = mtep_pkg::KIND_PROG;
                d1   = b[6:0];
              end
              phase_d = PH_DELTA;
              delta_d = 28'd0;
            end else begin
              held_d  = b;
              phase_d = PH_DATA2;
            end
          end
          PH_DATA2: begin
            emit = 1'b1;
            ch   = rstat_q[3:0];
            if (rstat_q[7:4] == 4'h8 || rstat_q[7:4] == 4'h9) begin
              d1 = held_q[6:0];
              d2 = b[6:0];
              kind = (rstat_q[7:4] == 4'h9 && b[6:0] != 7'd0) ?
                     mtep_pkg::KIND_ON : mtep_pkg::KIND_OFF;
            end
            phase_d = PH_DELTA;
            delta_d = 28'd0;
          end
          PH_SYSEX: begin
            if (b == 8'hF7) begin
              emit = 1'b1;
              phase_d = PH_DELTA;
              delta_d = 28'd0;
            end
          end
          PH_MTYPE: begin
            held_d  = b;
            phase_d = PH_MLEN;
          end
          PH_MLEN: begin
            skip_d   = b;
            tempo_d  = 24'd0;
            tempo_nx = 24'd0;
            if (b == 8'd0) meta_done = 1'b1;
            else phase_d = PH_MSKIP;
          end
          PH_MSKIP: begin
            if (held_q == 8'h51) tempo_d = {tempo_q[15:0], b};
            tempo_nx = tempo_d;
            skip_d   = skip_dec;
            if (skip_dec == 8'd0) meta_done = 1'b1;
          end
          default: begin
            emit = 1'b1;
            kind = mtep_pkg::KIND_ERROR;
            phase_d = PH_HALT;
          end
        endcase
        // Meta event fully consumed.
        if (meta_done) begin
          if (meta_type == 8'h2F) begin
            emit     = 1'b1;
            kind     = mtep_pkg::KIND_END;
            track_d  = track_q + 16'd1;
            phase_d  = PH_HEADER;
            skip_d   = 8'd0;
            hdr_d    = 32'd0;
            delta_d  = 28'd0;
            rstat_d  = 8'd0;
          end else begin
            if (meta_type == 8'h51) begin
              emit = 1'b1;
              kind = mtep_pkg::KIND_TEMPO;
              tv   = tempo_nx;
            end else if (meta_type != 8'h03) begin
              emit = 1'b1;
            end
            phase_d = PH_DELTA;
            delta_d = 28'd0;
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hdr_q    <= '0;
      remain_q <= '0;
      delta_q  <= '0;
      rstat_q  <= '0;
      skip_q   <= '0;
      held_q   <= '0;
      tempo_q  <= '0;
      track_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      remain_q <= remain_d;
      delta_q  <= delta_d;
      rstat_q  <= rstat_d;
      skip_q   <= skip_d;
      held_q   <= held_d;
      tempo_q  <= tempo_d;
      track_q  <= track_d;
    end
  end

  // The record carries the delta and track as they stood before this byte.
  assign rec_valid_o       = emit;
  assign rec_o.event_kind  = kind;
  assign rec_o.track_index = track_q;
  assign rec_o.delta_ticks = (phase_q == PH_DELTA) ? delta_d : delta_q;
  assign rec_o.channel     = ch;
  assign rec_o.first_data  = d1;
  assign rec_o.second_data = d2;
  assign rec_o.tempo_value = tv;

  // Once halted, the parser stays halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |=> phase_q == PH_HALT)
    else $error("parser left the halted phase");
  // An error record always halts the parser.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && rec_o.event_kind == mtep_pkg::KIND_ERROR |=> phase_q == PH_HALT)
    else $error("error record without halt");
  // No record while halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> !rec_valid_o)
    else $error("record emitted while halted");

endmodule

FILE: hw/rtl/mtep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser record queue
// Small FIFO between the parser and the result port.
// ----------------------------------------------------------------------------
module mtep_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  mtep_pkg::record_t wdata_i,
  input  logic              rd_i,
  output mtep_pkg::record_t rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  mtep_pkg::record_t mem_q [Depth];
  logic [Aw-1:0] wptr_q, rptr_q;
  logic [Aw:0]   cnt_q;
  logic          do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_rd) rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(do_wr) - (Aw+1)'(do_rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (Aw+1)'(Depth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rd && !do_wr |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count missed a read");

endmodule
